// File: src/esbc_pkg.sv
// ----------------------------------------------------------------------------
// esbc_pkg
// Shared types and constants of the ELF segment bounds checker: item and
// result payloads, status codes, register indexes and the page geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package esbc_pkg;

    // page geometry and segment limit
    localparam int unsigned PAGE_SHIFT   = 12;
    localparam int unsigned MAX_SEGMENTS = 16;
    localparam int unsigned CNT_W        = $clog2(MAX_SEGMENTS + 1);

    localparam logic [63:0] PAGE_MASK = (64'd1 << PAGE_SHIFT) - 64'd1;

    // reset values of the configuration registers
    localparam logic [31:0] FILE_SIZE_RST    = 32'd1;
    localparam logic [63:0] ENTRY_ADDR_RST   = 64'd0;
    localparam logic [63:0] USER_FLOOR_RST   = 64'd4096;
    localparam logic [63:0] USER_CEIL_RST    = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] SPAN_LIMIT_RST   = 64'd1073741824;
    localparam logic [63:0] MAPPED_LIMIT_RST = 64'd1073741824;

    // item kinds
    localparam logic KIND_SEG = 1'b0;
    localparam logic KIND_END = 1'b1;

    // permission bits in seg_flags
    localparam int unsigned FLAG_X = 0;
    localparam int unsigned FLAG_W = 1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_TOO_MANY = 3'd1,
        ST_INVALID  = 3'd2,
        ST_WX       = 3'd3,
        ST_RANGE    = 3'd4,
        ST_NO_SEG   = 3'd5,
        ST_ENTRY    = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        CFG_FILE_SIZE    = 3'd0,
        CFG_ENTRY_ADDR   = 3'd1,
        CFG_USER_FLOOR   = 3'd2,
        CFG_USER_CEIL    = 3'd3,
        CFG_SPAN_LIMIT   = 3'd4,
        CFG_MAPPED_LIMIT = 3'd5
    } t_cfg_idx;

    // one input item
    typedef struct packed {
        logic        kind;
        logic [2:0]  seg_flags;
        logic [63:0] seg_offset;
        logic [63:0] seg_file_len;
        logic [63:0] seg_mem_len;
        logic [63:0] seg_vaddr;
    } t_seg_item;

    // one result item
    typedef struct packed {
        logic [2:0]  status;
        logic        verdict;
        logic [4:0]  seg_total;
        logic [63:0] image_base;
        logic [63:0] image_len;
        logic        entry_ok;
    } t_res_item;

    // configuration seen by the segment checks
    typedef struct packed {
        logic [31:0] file_size;
        logic [63:0] entry_address;
        logic [63:0] user_floor;
        logic [63:0] user_ceiling;
        logic [63:0] span_limit;
    } t_chk_cfg;

    // stateless check results of one item
    typedef struct packed {
        logic        kind_end;
        t_status     fault;
        logic        empty;
        logic [63:0] pstart;
        logic [63:0] pend;
        logic        hit;
    } t_seg_chk;

    // segment count folded to the 5-bit result field
    function automatic logic [4:0] cnt_to_total(input logic [CNT_W-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return wide[4:0];
    endfunction

endpackage

`default_nettype wire

// File: src/esbc_in_if.sv
// ----------------------------------------------------------------------------
// esbc_in_if
// Valid/ready channel that carries segment descriptors and end markers.
// ----------------------------------------------------------------------------
`default_nettype none

interface esbc_in_if;
    import esbc_pkg::*;

    logic      valid;
    logic      ready;
    t_seg_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/esbc_out_if.sv
// ----------------------------------------------------------------------------
// esbc_out_if
// Valid/ready channel that carries check results and image verdicts.
// ----------------------------------------------------------------------------
`default_nettype none

interface esbc_out_if;
    import esbc_pkg::*;

    logic      valid;
    logic      ready;
    t_res_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: src/esbc_seg_check.sv
// ----------------------------------------------------------------------------
// esbc_seg_check
// Per-segment checks that do not depend on the running image state: file
// range, write-plus-execute, end address overflow, page rounding, span and
// user window, and whether the entry point falls inside the segment.
// ----------------------------------------------------------------------------
`default_nettype none

module esbc_seg_check (
    input  var esbc_pkg::t_seg_item i_item,
    input  var esbc_pkg::t_chk_cfg  i_cfg,
    output var esbc_pkg::t_seg_chk  o_chk
);
    import esbc_pkg::*;

    logic [64:0] seg_end_w;
    logic [64:0] rnd_w;
    logic [63:0] seg_end;
    logic [63:0] pstart;
    logic [63:0] pend;
    logic [63:0] fsize;
    logic        bad_file;
    logic        empty;
    logic        wx;
    logic        bad_addr;
    logic        bad_win;

    // end address and page-rounded end, carry out means overflow
    assign seg_end_w = {1'b0, i_item.seg_vaddr} + {1'b0, i_item.seg_mem_len};
    assign seg_end   = seg_end_w[63:0];
    assign rnd_w     = {1'b0, seg_end} + {1'b0, PAGE_MASK};
    assign pstart    = i_item.seg_vaddr & ~PAGE_MASK;
    assign pend      = rnd_w[63:0] & ~PAGE_MASK;

    // file range
    assign fsize    = {32'd0, i_cfg.file_size};
    assign bad_file = (i_item.seg_file_len > i_item.seg_mem_len)
                   || (i_item.seg_offset > fsize)
                   || (i_item.seg_file_len > (fsize - i_item.seg_offset));

    assign empty = (i_item.seg_mem_len == 64'd0);
    assign wx    = i_item.seg_flags[FLAG_W] && i_item.seg_flags[FLAG_X];

    assign bad_addr = seg_end_w[64] || (seg_end <= i_item.seg_vaddr) || rnd_w[64];
    assign bad_win  = (pstart < i_cfg.user_floor)
                   || (pend <= pstart)
                   || ((pend - pstart) > i_cfg.span_limit)
                   || ((pend - 64'd1) > i_cfg.user_ceiling);

    // first failing check in priority order
    always_comb begin
        o_chk.kind_end = (i_item.kind == KIND_END);
        o_chk.empty    = 1'b0;
        o_chk.pstart   = pstart;
        o_chk.pend     = pend;
        o_chk.hit      = i_item.seg_flags[FLAG_X]
                      && (i_cfg.entry_address >= i_item.seg_vaddr)
                      && (i_cfg.entry_address < seg_end);
        if (bad_file) begin
            o_chk.fault = ST_INVALID;
        end else if (empty) begin
            o_chk.fault = ST_OK;
            o_chk.empty = 1'b1;
        end else if (wx) begin
            o_chk.fault = ST_WX;
        end else if (bad_addr || bad_win) begin
            o_chk.fault = ST_RANGE;
        end else begin
            o_chk.fault = ST_OK;
        end
    end

endmodule

`default_nettype wire

// File: src/elf_segment_bounds_checker_unit.sv
// ----------------------------------------------------------------------------
// elf_segment_bounds_checker_unit
// Checks ELF loadable-segment descriptors and gives a verdict per image.
//
// Usage:
//  - i_item takes one segment descriptor (kind 0) or an end-of-image marker
//    (kind 1) per handshake; o_result returns exactly one result per item,
//    in order. Segment results carry the sticky first fault and the running
//    base, length, count and entry flag; the marker's result has verdict 1,
//    the final status, and clears the image state.
//  - Three register stages: input register, check register, result
//    register. A result becomes valid once its item has passed through
//    all three in turn.
//  - Throughput is one item per cycle while the receiver takes results; the
//    state update (min/max, count, sticky fault) is combinational between
//    the check and result registers.
//  - A stalled receiver holds the result register; up to two more items are
//    taken into the input and check registers before i_item.ready drops.
//  - Reset (i_rst_n low, synchronous) empties the pipeline, clears the image
//    state and loads the register defaults. Registers are written through
//    i_cfg_we/i_cfg_idx/i_cfg_data; the user must write them only while
//    the block is idle (not enforced by the block); unknown indexes are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module elf_segment_bounds_checker_unit (
    input  var logic          i_clk,
    input  var logic          i_rst_n,
    input  var logic          i_cfg_we,
    input  var logic [2:0]    i_cfg_idx,
    input  var logic [63:0]   i_cfg_data,
    esbc_in_if.sink           i_item,
    esbc_out_if.source        o_result
);
    import esbc_pkg::*;

    // configuration registers
    logic [31:0] r_file_size;
    logic [63:0] r_entry_address;
    logic [63:0] r_user_floor;
    logic [63:0] r_user_ceiling;
    logic [63:0] r_span_limit;
    logic [63:0] r_mapped_limit;

    // pipeline registers
    logic      r_in_v;
    t_seg_item r_in;
    logic      r_chk_v;
    t_seg_chk  r_chk;
    logic      r_out_v;
    t_res_item r_out;

    // image state
    t_status        r_fault,  n_fault;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic [63:0]    r_low,    n_low;
    logic [63:0]    r_high,   n_high;
    logic           r_hit,    n_hit;

    t_chk_cfg  chk_cfg;
    t_seg_chk  chk;
    t_res_item n_out;
    logic      out_free;
    logic      adv_chk;
    logic      chk_free;
    logic      adv_in;
    logic [63:0] cur_len;

    // handshake across the three stages
    assign out_free = !r_out_v || o_result.ready;
    assign adv_chk  = r_chk_v && out_free;
    assign chk_free = !r_chk_v || adv_chk;
    assign adv_in   = r_in_v && chk_free;

    assign i_item.ready   = !r_in_v || adv_in;
    assign o_result.valid = r_out_v;
    assign o_result.data  = r_out;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_size     <= FILE_SIZE_RST;
            r_entry_address <= ENTRY_ADDR_RST;
            r_user_floor    <= USER_FLOOR_RST;
            r_user_ceiling  <= USER_CEIL_RST;
            r_span_limit    <= SPAN_LIMIT_RST;
            r_mapped_limit  <= MAPPED_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_FILE_SIZE:    r_file_size     <= i_cfg_data[31:0];
                CFG_ENTRY_ADDR:   r_entry_address <= i_cfg_data;
                CFG_USER_FLOOR:   r_user_floor    <= i_cfg_data;
                CFG_USER_CEIL:    r_user_ceiling  <= i_cfg_data;
                CFG_SPAN_LIMIT:   r_span_limit    <= i_cfg_data;
                CFG_MAPPED_LIMIT: r_mapped_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stateless per-segment checks
    assign chk_cfg.file_size     = r_file_size;
    assign chk_cfg.entry_address = r_entry_address;
    assign chk_cfg.user_floor    = r_user_floor;
    assign chk_cfg.user_ceiling  = r_user_ceiling;
    assign chk_cfg.span_limit    = r_span_limit;

    esbc_seg_check u_check (
        .i_item (r_in),
        .i_cfg  (chk_cfg),
        .o_chk  (chk)
    );

    // image length from the current state
    assign cur_len = (r_high > r_low) ? (r_high - r_low) : 64'd0;

    // state update and result for the item in the check register
    always_comb begin
        n_fault = r_fault;
        n_cnt   = r_cnt;
        n_low   = r_low;
        n_high  = r_high;
        n_hit   = r_hit;
        n_out   = '0;
        if (!r_chk.kind_end) begin
            if (r_fault == ST_OK) begin
                if (r_cnt >= CNT_W'(MAX_SEGMENTS)) begin
                    n_fault = ST_TOO_MANY;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                    if (r_chk.fault != ST_OK) begin
                        n_fault = r_chk.fault;
                    end else if (!r_chk.empty) begin
                        if ((r_low == 64'd0) || (r_chk.pstart < r_low)) begin
                            n_low = r_chk.pstart;
                        end
                        if (r_chk.pend > r_high) begin
                            n_high = r_chk.pend;
                        end
                        if (r_chk.hit) begin
                            n_hit = 1'b1;
                        end
                    end
                end
            end
            n_out.status     = n_fault;
            n_out.verdict    = 1'b0;
            n_out.seg_total  = cnt_to_total(n_cnt);
            n_out.image_base = n_low;
            n_out.image_len  = (n_high > n_low) ? (n_high - n_low) : 64'd0;
            n_out.entry_ok   = n_hit;
        end else begin
            n_out.verdict    = 1'b1;
            n_out.seg_total  = cnt_to_total(r_cnt);
            n_out.image_base = r_low;
            n_out.image_len  = cur_len;
            n_out.entry_ok   = r_hit;
            if (r_fault != ST_OK) begin
                n_out.status = r_fault;
            end else if ((r_cnt == '0) || (r_low == 64'd0) || (r_high <= r_low)) begin
                n_out.status     = ST_NO_SEG;
                n_out.seg_total  = 5'd0;
                n_out.image_base = 64'd0;
                n_out.image_len  = 64'd0;
                n_out.entry_ok   = 1'b0;
            end else if (!r_hit) begin
                n_out.status = ST_ENTRY;
            end else if (cur_len > r_mapped_limit) begin
                n_out.status = ST_RANGE;
            end else begin
                n_out.status = ST_OK;
            end
            // verdict closes the image
            n_fault = ST_OK;
            n_cnt   = '0;
            n_low   = 64'd0;
            n_high  = 64'd0;
            n_hit   = 1'b0;
        end
    end

    // pipeline valids and image state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_chk_v <= 1'b0;
            r_out_v <= 1'b0;
            r_fault <= ST_OK;
            r_cnt   <= '0;
            r_low   <= 64'd0;
            r_high  <= 64'd0;
            r_hit   <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_v <= i_item.valid;
            end
            if (chk_free) begin
                r_chk_v <= r_in_v;
            end
            if (out_free) begin
                r_out_v <= r_chk_v;
            end
            if (adv_chk) begin
                r_fault <= n_fault;
                r_cnt   <= n_cnt;
                r_low   <= n_low;
                r_high  <= n_high;
                r_hit   <= n_hit;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in <= i_item.data;
        end
        if (adv_in) begin
            r_chk <= chk;
        end
        if (adv_chk) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire
